// File: hdl/ffdbp_pkg.sv
`timescale 1ns / 1ps
// shared constants and the sequencer state type of the first-fit-decreasing bin packer
package ffdbp_pkg;

    localparam int SIZE_BITS     = 10;
    localparam int CAP_BITS      = 10;
    localparam int CAP_RESET     = 10;
    localparam int MAX_ITEMS_DEF = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SWAP_HI,
        ST_SWAP_LO,
        ST_FIT,
        ST_OUT_RD,
        ST_OUT_LD
    } ffdbp_state_t;

endpackage

// File: hdl/ffdbp_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for item input and placement results
interface ffdbp_in_if import ffdbp_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [SIZE_BITS-1:0] item_size;
    logic                 last_item;

    modport source (output valid, output item_size, output last_item, input ready);
    modport sink   (input valid, input item_size, input last_item, output ready);
endinterface

interface ffdbp_out_if import ffdbp_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
);
    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic                 valid;
    logic                 ready;
    logic [SIZE_BITS-1:0] placed_size;
    logic [IDX_W-1:0]     bin_index;
    logic [CNT_W-1:0]     bins_used;
    logic                 oversize;
    logic                 last_result;

    modport source (output valid, output placed_size, output bin_index, output bins_used,
                    output oversize, output last_result, input ready);
    modport sink   (input valid, input placed_size, input bin_index, input bins_used,
                    input oversize, input last_result, output ready);
endinterface

// File: hdl/first_fit_decreasing_bin_packer.sv
`timescale 1ns / 1ps
// items load one per cycle; after the last one, each sorted position gets a selection scan and
// swap in the item ram, then, unless it is oversize, a first-fit scan of the bin ram up to the
// chosen bin; results then drain one at a time through the output register
// one set at a time: no item of the next set is taken until the last result of this one is
// loaded into the output register
// reset: asynchronous active low; bin capacity returns to 10, counts clear, ram contents are kept
module first_fit_decreasing_bin_packer import ffdbp_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CAP_BITS-1:0] cfg_wr_data,
    ffdbp_in_if.sink            item_in,
    ffdbp_out_if.source         result_out
);

    localparam int IDX_W = $clog2(MAX_ITEMS);

    // bin capacity register; the user must write it only while the block is idle, not enforced here
    logic [CAP_BITS-1:0] cap_reg, cap_next;

    assign cap_next = cfg_wr_en ? cfg_wr_data : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_BITS'(CAP_RESET);
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    // item ram: loaded in arrival order, sorted in place by the sequencer
    logic                 item_wr_en;
    logic [IDX_W-1:0]     item_wr_addr;
    logic [SIZE_BITS-1:0] item_wr_data;
    logic                 item_rd_en;
    logic [IDX_W-1:0]     item_rd_addr;
    logic [SIZE_BITS-1:0] item_rd_data;

    // bin fill ram: the entry at the open-bin count reads as empty
    logic                 bin_wr_en;
    logic [IDX_W-1:0]     bin_wr_addr;
    logic [SIZE_BITS-1:0] bin_wr_data;
    logic                 bin_rd_en;
    logic [IDX_W-1:0]     bin_rd_addr;
    logic [SIZE_BITS-1:0] bin_rd_data;

    // assignment ram: chosen bin per sorted position
    logic                 asg_wr_en;
    logic [IDX_W-1:0]     asg_wr_addr;
    logic [IDX_W-1:0]     asg_wr_data;
    logic                 asg_rd_en;
    logic [IDX_W-1:0]     asg_rd_addr;
    logic [IDX_W-1:0]     asg_rd_data;

    ffdbp_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_item_ram (
        .clk     (clk),
        .wr_en   (item_wr_en),
        .wr_addr (item_wr_addr),
        .wr_data (item_wr_data),
        .rd_en   (item_rd_en),
        .rd_addr (item_rd_addr),
        .rd_data (item_rd_data)
    );

    ffdbp_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_bin_ram (
        .clk     (clk),
        .wr_en   (bin_wr_en),
        .wr_addr (bin_wr_addr),
        .wr_data (bin_wr_data),
        .rd_en   (bin_rd_en),
        .rd_addr (bin_rd_addr),
        .rd_data (bin_rd_data)
    );

    ffdbp_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ITEMS)
    ) u_asg_ram (
        .clk     (clk),
        .wr_en   (asg_wr_en),
        .wr_addr (asg_wr_addr),
        .wr_data (asg_wr_data),
        .rd_en   (asg_rd_en),
        .rd_addr (asg_rd_addr),
        .rd_data (asg_rd_data)
    );

    // sequencer owns the input transfer, the ram traffic and the output register
    ffdbp_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cap          (cap_reg),
        .item_in      (item_in),
        .result_out   (result_out),
        .item_wr_en   (item_wr_en),
        .item_wr_addr (item_wr_addr),
        .item_wr_data (item_wr_data),
        .item_rd_en   (item_rd_en),
        .item_rd_addr (item_rd_addr),
        .item_rd_data (item_rd_data),
        .bin_wr_en    (bin_wr_en),
        .bin_wr_addr  (bin_wr_addr),
        .bin_wr_data  (bin_wr_data),
        .bin_rd_en    (bin_rd_en),
        .bin_rd_addr  (bin_rd_addr),
        .bin_rd_data  (bin_rd_data),
        .asg_wr_en    (asg_wr_en),
        .asg_wr_addr  (asg_wr_addr),
        .asg_wr_data  (asg_wr_data),
        .asg_rd_en    (asg_rd_en),
        .asg_rd_addr  (asg_rd_addr),
        .asg_rd_data  (asg_rd_data)
    );

endmodule

// File: hdl/ffdbp_ram.sv
`timescale 1ns / 1ps
// simple dual-port synchronous ram, one write and one registered read port
module ffdbp_ram import ffdbp_pkg::*; #(
    parameter int WIDTH = SIZE_BITS,
    parameter int DEPTH = MAX_ITEMS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/ffdbp_ctrl.sv
`timescale 1ns / 1ps
// sequencer: load, selection sort in the item ram, first-fit scan of the bin ram, result drain
module ffdbp_ctrl import ffdbp_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [CAP_BITS-1:0]             cap,
    ffdbp_in_if.sink                        item_in,
    ffdbp_out_if.source                     result_out,
    // item ram
    output logic                            item_wr_en,
    output logic [$clog2(MAX_ITEMS)-1:0]    item_wr_addr,
    output logic [SIZE_BITS-1:0]            item_wr_data,
    output logic                            item_rd_en,
    output logic [$clog2(MAX_ITEMS)-1:0]    item_rd_addr,
    input  logic [SIZE_BITS-1:0]            item_rd_data,
    // bin fill ram
    output logic                            bin_wr_en,
    output logic [$clog2(MAX_ITEMS)-1:0]    bin_wr_addr,
    output logic [SIZE_BITS-1:0]            bin_wr_data,
    output logic                            bin_rd_en,
    output logic [$clog2(MAX_ITEMS)-1:0]    bin_rd_addr,
    input  logic [SIZE_BITS-1:0]            bin_rd_data,
    // assignment ram
    output logic                            asg_wr_en,
    output logic [$clog2(MAX_ITEMS)-1:0]    asg_wr_addr,
    output logic [$clog2(MAX_ITEMS)-1:0]    asg_wr_data,
    output logic                            asg_rd_en,
    output logic [$clog2(MAX_ITEMS)-1:0]    asg_rd_addr,
    input  logic [$clog2(MAX_ITEMS)-1:0]    asg_rd_data
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    ffdbp_state_t state_reg, state_next;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [CNT_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [SIZE_BITS-1:0] max_val_reg, max_val_next;
    logic [CNT_W-1:0]     max_idx_reg, max_idx_next;
    logic [SIZE_BITS-1:0] first_val_reg, first_val_next;
    logic [CNT_W-1:0]     total_reg, total_next;

    logic                 out_valid_reg, out_valid_next;
    logic [SIZE_BITS-1:0] placed_size_reg;
    logic [IDX_W-1:0]     bin_index_reg;
    logic [CNT_W-1:0]     bins_used_reg;
    logic                 oversize_reg;
    logic                 last_result_reg;

    logic                 accept;
    logic                 room;
    logic                 scan_done;
    logic                 pos_last;
    logic [SIZE_BITS-1:0] fill_cur;
    logic [SIZE_BITS:0]   fit_sum;
    logic [SIZE_BITS:0]   cap_ext;
    logic                 fit_hit;
    logic                 item_over;
    logic                 out_free;
    logic                 out_load;

    assign accept    = item_in.valid && item_in.ready;
    assign room      = count_reg < CNT_W'(MAX_ITEMS);
    assign scan_done = chk_valid_reg && (chk_idx_reg == count_reg - CNT_W'(1));
    assign pos_last  = pos_reg == count_reg - CNT_W'(1);
    // the bin at the open-bin count is empty
    assign fill_cur  = (chk_idx_reg == total_reg) ? '0 : bin_rd_data;
    assign fit_sum   = {1'b0, fill_cur} + {1'b0, max_val_reg};
    assign cap_ext   = (SIZE_BITS + 1)'(cap);
    assign fit_hit   = chk_valid_reg && (fit_sum <= cap_ext);
    assign item_over = {1'b0, max_val_reg} > cap_ext;
    assign out_free  = !out_valid_reg || result_out.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && item_in.last_item)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_SWAP_HI;
                end
            end
            ST_SWAP_HI:
            begin
                state_next = ST_SWAP_LO;
            end
            ST_SWAP_LO:
            begin
                if (!item_over)
                begin
                    state_next = ST_FIT;
                end
                else if (pos_last)
                begin
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_FIT:
            begin
                if (fit_hit)
                begin
                    state_next = pos_last ? ST_OUT_RD : ST_SCAN;
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                if (out_free)
                begin
                    state_next = pos_last ? ST_LOAD : ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // memory controls and handshake
    always_comb
    begin
        item_in.ready = 1'b0;
        item_wr_en    = 1'b0;
        item_wr_addr  = count_reg[IDX_W-1:0];
        item_wr_data  = item_in.item_size;
        item_rd_en    = 1'b0;
        item_rd_addr  = ptr_reg[IDX_W-1:0];
        bin_wr_en     = 1'b0;
        bin_wr_addr   = chk_idx_reg[IDX_W-1:0];
        bin_wr_data   = fit_sum[SIZE_BITS-1:0];
        bin_rd_en     = 1'b0;
        bin_rd_addr   = ptr_reg[IDX_W-1:0];
        asg_wr_en     = 1'b0;
        asg_wr_addr   = pos_reg[IDX_W-1:0];
        asg_wr_data   = chk_idx_reg[IDX_W-1:0];
        asg_rd_en     = 1'b0;
        asg_rd_addr   = pos_reg[IDX_W-1:0];
        out_load      = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                item_in.ready = 1'b1;
                item_wr_en    = accept && room;
            end
            ST_SCAN:
            begin
                item_rd_en = ptr_reg < count_reg;
            end
            ST_SWAP_HI:
            begin
                item_wr_en   = 1'b1;
                item_wr_addr = pos_reg[IDX_W-1:0];
                item_wr_data = max_val_reg;
            end
            ST_SWAP_LO:
            begin
                item_wr_en   = 1'b1;
                item_wr_addr = max_idx_reg[IDX_W-1:0];
                item_wr_data = first_val_reg;
                asg_wr_en    = item_over;
                asg_wr_data  = '0;
            end
            ST_FIT:
            begin
                bin_rd_en = 1'b1;
                bin_wr_en = fit_hit;
                asg_wr_en = fit_hit;
            end
            ST_OUT_RD:
            begin
                item_rd_en   = 1'b1;
                item_rd_addr = pos_reg[IDX_W-1:0];
                asg_rd_en    = 1'b1;
            end
            ST_OUT_LD:
            begin
                out_load = out_free;
            end
            default:
            begin
                item_in.ready = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        count_next     = count_reg;
        pos_next       = pos_reg;
        ptr_next       = ptr_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        max_val_next   = max_val_reg;
        max_idx_next   = max_idx_reg;
        first_val_next = first_val_reg;
        total_next     = total_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && room)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (accept && item_in.last_item)
                begin
                    pos_next       = '0;
                    ptr_next       = '0;
                    chk_valid_next = 1'b0;
                    total_next     = '0;
                end
            end
            ST_SCAN:
            begin
                if (item_rd_en)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                chk_valid_next = item_rd_en;
                chk_idx_next   = ptr_reg;
                if (chk_valid_reg)
                begin
                    if (chk_idx_reg == pos_reg)
                    begin
                        max_val_next   = item_rd_data;
                        max_idx_next   = chk_idx_reg;
                        first_val_next = item_rd_data;
                    end
                    else if (item_rd_data > max_val_reg)
                    begin
                        max_val_next = item_rd_data;
                        max_idx_next = chk_idx_reg;
                    end
                end
            end
            ST_SWAP_LO:
            begin
                chk_valid_next = 1'b0;
                if (item_over)
                begin
                    pos_next = pos_last ? '0 : pos_reg + CNT_W'(1);
                    ptr_next = pos_reg + CNT_W'(1);
                end
                else
                begin
                    ptr_next = '0;
                end
            end
            ST_FIT:
            begin
                ptr_next       = ptr_reg + CNT_W'(1);
                chk_valid_next = 1'b1;
                chk_idx_next   = ptr_reg;
                if (fit_hit)
                begin
                    if (chk_idx_reg == total_reg)
                    begin
                        total_next = total_reg + CNT_W'(1);
                    end
                    pos_next       = pos_last ? '0 : pos_reg + CNT_W'(1);
                    ptr_next       = pos_reg + CNT_W'(1);
                    chk_valid_next = 1'b0;
                end
            end
            ST_OUT_LD:
            begin
                if (out_load)
                begin
                    if (pos_last)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            pos_reg       <= '0;
            ptr_reg       <= '0;
            chk_valid_reg <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            ptr_reg       <= ptr_next;
            chk_valid_reg <= chk_valid_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        max_val_reg   <= max_val_next;
        max_idx_reg   <= max_idx_next;
        first_val_reg <= first_val_next;
        if (out_load)
        begin
            placed_size_reg <= item_rd_data;
            bin_index_reg   <= asg_rd_data;
            bins_used_reg   <= total_reg;
            oversize_reg    <= {1'b0, item_rd_data} > cap_ext;
            last_result_reg <= pos_last;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.placed_size = placed_size_reg;
    assign result_out.bin_index   = bin_index_reg;
    assign result_out.bins_used   = bins_used_reg;
    assign result_out.oversize    = oversize_reg;
    assign result_out.last_result = last_result_reg;

    // a freshly opened bin always takes an item that is not oversize
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIT && chk_valid_reg && chk_idx_reg == total_reg) |-> fit_hit)
        else $error("first empty bin rejected an item");

    // open bins never outnumber the items of the set
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (total_reg <= count_reg))
        else $error("bin count exceeds item count");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond store depth");

    // an unplaced item always reports bin zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && oversize_reg) |-> (bin_index_reg == '0))
        else $error("oversize result carries a bin");

endmodule

// File: test/tb_first_fit_decreasing_bin_packer.sv
`timescale 1ns / 1ps
// self-checking testbench for the first-fit-decreasing bin packer with its own packing predictor
module tb_first_fit_decreasing_bin_packer;
    import ffdbp_pkg::*;

    localparam int MAX_ITEMS = MAX_ITEMS_DEF;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int SIZE_MAX  = (1 << SIZE_BITS) - 1;
    localparam int CAP_MAX   = (1 << CAP_BITS) - 1;
    localparam int LONG_HOLD = 700;
    localparam int DRAIN_GAP = 16;

    typedef struct {
        logic [SIZE_BITS-1:0] size;
        logic                 last;
    } load_t;

    typedef struct {
        logic [SIZE_BITS-1:0] size;
        logic [IDX_W-1:0]     bin;
        logic [CNT_W-1:0]     used;
        logic                 over;
        logic                 last;
    } placement_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [CAP_BITS-1:0] cfg_wr_data;
    logic hold_req;
    int   hold_left;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   fail_count = 0;

    // items waiting to be offered, placements waiting to come back
    load_t      load_q[$];
    placement_t placement_q[$];

    // predictor state: capacity copy and sizes of the set being loaded
    int capacity_model = CAP_RESET;
    int set_sizes[MAX_ITEMS];
    int set_count = 0;

    ffdbp_in_if                              in_ch ();
    ffdbp_out_if #(.MAX_ITEMS(MAX_ITEMS))    res_ch ();

    first_fit_decreasing_bin_packer #(.MAX_ITEMS(MAX_ITEMS)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_in     (in_ch.sink),
        .result_out  (res_ch.source)
    );

    always #4 clk = ~clk;

    // collects one accepted size; on the last marker sorts, packs and queues the placements
    function automatic void take_item(load_t it);
        int sorted[MAX_ITEMS];
        int fill[MAX_ITEMS];
        int bin_of[MAX_ITEMS];
        int used;
        int i;
        int j;
        int v;
        placement_t p;
        if (set_count < MAX_ITEMS)
        begin
            set_sizes[set_count] = int'(it.size);
            set_count++;
        end
        if (!it.last)
            return;
        for (i = 0; i < set_count; i++)
        begin
            v = set_sizes[i];
            j = i;
            while (j > 0 && sorted[j - 1] < v)
            begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = v;
        end
        for (i = 0; i < MAX_ITEMS; i++)
            fill[i] = 0;
        used = 0;
        for (i = 0; i < set_count; i++)
        begin
            bin_of[i] = 0;
            if (sorted[i] > capacity_model)
                continue;
            for (j = 0; j < MAX_ITEMS - 1; j++)
                if (fill[j] + sorted[i] <= capacity_model)
                    break;
            fill[j] += sorted[i];
            bin_of[i] = j;
            if (used < j + 1)
                used = j + 1;
        end
        for (i = 0; i < set_count; i++)
        begin
            p.size = SIZE_BITS'(sorted[i]);
            p.bin  = IDX_W'(bin_of[i]);
            p.used = CNT_W'(used);
            p.over = (sorted[i] > capacity_model);
            p.last = (i + 1 == set_count);
            placement_q.push_back(p);
        end
        set_count = 0;
    endfunction

    // driver: holds an offered item until its transfer, then maybe idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.item_size <= '0;
            in_ch.last_item <= 1'b0;
        end
        else if (!(in_ch.valid && !in_ch.ready))
        begin
            if (in_ch.valid)
                take_item(load_q.pop_front());
            if (load_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_ch.valid     <= 1'b1;
                in_ch.item_size <= load_q[0].size;
                in_ch.last_item <= load_q[0].last;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= LONG_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor: checks each result transfer against the oldest placement
    always @(posedge clk or negedge rst_n)
    begin
        placement_t e;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (placement_q.size() == 0)
                begin
                    $error("result transfer with no placement expected");
                    fail_count++;
                end
                else
                begin
                    e = placement_q.pop_front();
                    if (res_ch.placed_size !== e.size)
                    begin
                        $error("placed_size: expected %0d, got %0d", e.size, res_ch.placed_size);
                        fail_count++;
                    end
                    if (res_ch.bin_index !== e.bin)
                    begin
                        $error("bin_index: expected %0d, got %0d", e.bin, res_ch.bin_index);
                        fail_count++;
                    end
                    if (res_ch.bins_used !== e.used)
                    begin
                        $error("bins_used: expected %0d, got %0d", e.used, res_ch.bins_used);
                        fail_count++;
                    end
                    if (res_ch.oversize !== e.over)
                    begin
                        $error("oversize: expected %0d, got %0d", e.over, res_ch.oversize);
                        fail_count++;
                    end
                    if (res_ch.last_result !== e.last)
                    begin
                        $error("last_result: expected %0d, got %0d", e.last, res_ch.last_result);
                        fail_count++;
                    end
                end
            end
            res_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic add_item(int size, bit last);
        load_t it;
        it.size = SIZE_BITS'(size);
        it.last = last;
        @(negedge clk);
        load_q.push_back(it);
    endtask

    // waits until every placement is back and the block has gone quiet
    task automatic settle();
        while (load_q.size() != 0 || in_ch.valid || placement_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    task automatic write_capacity(int v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CAP_BITS'(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        capacity_model = v;
    endtask

    // sizes spread over zero, max, exact fit, just over and mostly fitting values
    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 0;
        else if (r < 11)
            return SIZE_MAX;
        else if (r < 21)
            return $urandom_range(0, SIZE_MAX);
        else if (r < 28)
            return capacity_model;
        else if (r < 33)
            return (capacity_model < SIZE_MAX) ? capacity_model + 1 : SIZE_MAX;
        else if (r < 60)
            return $urandom_range(0, capacity_model / 3);
        else
            return $urandom_range(0, capacity_model);
    endfunction

    task automatic queue_random_set(int n);
        for (int i = 0; i < n; i++)
            add_item(pick_size(), i == n - 1);
    endtask

    initial
    begin
        int dir_mixed[8];
        int dir_wide[5];
        int dir_unit[5];
        int cap_plan[6];
        int sub_items;
        int n;
        int r;

        dir_mixed       = '{3, 7, 5, 5, 10, 0, 1023, 11};
        dir_wide        = '{1023, 1023, 512, 511, 0};
        dir_unit        = '{1, 1, 1, 0, 2};
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        hold_req        = 1'b0;
        send_idle_pct   = 38;
        recv_idle_pct   = 57;
        cap_plan = '{10, $urandom_range(2, CAP_MAX - 1), CAP_MAX, 7,
                     $urandom_range(2, CAP_MAX - 1), 1};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset capacity, mixed set with zero, exact fit and oversize items
        for (int i = 0; i < 8; i++)
            add_item(dir_mixed[i], i == 7);
        add_item(4, 1'b1);
        settle();
        // capacity zero: only zero-size items fit
        write_capacity(0);
        add_item(0, 1'b0);
        add_item(1, 1'b1);
        settle();
        write_capacity(CAP_MAX);
        for (int i = 0; i < 5; i++)
            add_item(dir_wide[i], i == 4);
        settle();
        write_capacity(1);
        for (int i = 0; i < 5; i++)
            add_item(dir_unit[i], i == 4);

        // random: three idling modes, two capacities each
        for (int sp = 0; sp < 6; sp++)
        begin
            settle();
            send_idle_pct = (sp < 2) ? 38 : (sp < 4) ? 57 : 0;
            recv_idle_pct = (sp < 2) ? 57 : (sp < 4) ? 38 : 0;
            write_capacity(cap_plan[sp]);
            sub_items = 0;
            // overfilled set: sizes past the store depth are dropped, last still closes it
            if (sp % 2 == 0)
            begin
                n = MAX_ITEMS + $urandom_range(1, 4);
                queue_random_set(n);
                sub_items += n;
            end
            while (sub_items < 52)
            begin
                r = $urandom_range(0, 99);
                n = (r < 80) ? $urandom_range(1, 8) :
                    (r < 95) ? $urandom_range(9, MAX_ITEMS) : $urandom_range(MAX_ITEMS + 1, 36);
                queue_random_set(n);
                sub_items += n;
                if (sp == 1 && sub_items < 20)
                begin
                    // receiver stalls long while items keep coming
                    @(negedge clk);
                    hold_req = 1'b1;
                    @(negedge clk);
                    hold_req = 1'b0;
                end
                if ($urandom_range(0, 9) == 0)
                    settle();
            end
        end

        settle();
        if (fail_count == 0 && placement_q.size() == 0)
            $display("first_fit_decreasing_bin_packer test passed");
        else
            $display("first_fit_decreasing_bin_packer test failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("first_fit_decreasing_bin_packer test failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/ffdbp_pkg.sv
hdl/ffdbp_if.sv
hdl/ffdbp_ram.sv
hdl/ffdbp_ctrl.sv
hdl/first_fit_decreasing_bin_packer.sv
test/tb_first_fit_decreasing_bin_packer.sv
